// ----- rtl/hjcf_pkg.sv -----
`timescale 1ns / 1ps

package hjcf_pkg;

    localparam int unsigned CMD_LEN      = 13;
    localparam int unsigned IDX_W        = $clog2(CMD_LEN);
    localparam int unsigned JOINTS       = 6;
    localparam int unsigned ACTION_W     = 5;
    localparam int unsigned SPEED_W      = 4;
    localparam int unsigned RESEND_W     = 8;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RESEND_W-1:0] RESEND_LIMIT  = 8'd3;
    localparam logic [SPEED_W-1:0]  SPEED_RESET   = 4'd3;
    localparam logic [SPEED_W-1:0]  SPEED_MAX     = 4'd9;
    localparam logic [ACTION_W-1:0] ACTION_STOP   = 5'd0;
    localparam logic [ACTION_W-1:0] ACTION_FIRST  = 5'd1;
    localparam logic [ACTION_W-1:0] ACTION_LAST   = 5'd26;
    localparam logic [IDX_W-1:0]    LAST_IDX      = IDX_W'(CMD_LEN - 1);

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef logic [JOINTS-1:0] t_mask;

    typedef struct packed {
        logic                has_stop;
        logic                stop_minus;
        logic                has_cmd;
        logic                cmd_minus;
        t_mask               cmd_mask;
        logic [SPEED_W-1:0]  cmd_digit;
    } t_desc;

    function automatic t_mask pair_mask(input logic [3:0] pair);
        t_mask m;
        case (pair)
            4'd0:    m = 6'h21;
            4'd1:    m = 6'h01;
            4'd2:    m = 6'h20;
            4'd3:    m = 6'h02;
            4'd4:    m = 6'h04;
            4'd5:    m = 6'h08;
            4'd6:    m = 6'h10;
            4'd7:    m = 6'h03;
            4'd8:    m = 6'h07;
            4'd9:    m = 6'h1F;
            4'd10:   m = 6'h23;
            4'd11:   m = 6'h3F;
            4'd12:   m = 6'h1C;
            default: m = 6'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] cmd_byte(input logic minus, input t_mask mask,
                                            input logic [SPEED_W-1:0] digit,
                                            input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        logic [IDX_W-2:0] joint;
        joint = idx[IDX_W-1:1];
        if (idx == LAST_IDX) begin
            b = CHAR_CR;
        end else if (!idx[0]) begin
            b = minus ? CHAR_MINUS : CHAR_PLUS;
        end else if (((mask >> joint) & t_mask'(1)) != '0) begin
            b = CHAR_ZERO + {4'd0, digit};
        end else begin
            b = CHAR_ZERO;
        end
        return b;
    endfunction

endpackage

// ----- rtl/hjcf_front.sv -----
`timescale 1ns / 1ps

module hjcf_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hjcf_pkg::SPEED_W-1:0] i_cfg_wdata,
    input  logic                         i_valid,
    input  logic [hjcf_pkg::ACTION_W-1:0] i_action,
    input  logic                         i_queue_full,
    output logic                         o_ready,
    output logic                         o_push,
    output hjcf_pkg::t_desc              o_desc
);

    logic [hjcf_pkg::SPEED_W-1:0]  r_speed;
    logic [hjcf_pkg::ACTION_W-1:0] r_prev, n_prev;
    logic [hjcf_pkg::RESEND_W-1:0] r_resend, n_resend;
    logic                          r_cmd_minus, n_cmd_minus;
    hjcf_pkg::t_mask               r_cmd_mask, n_cmd_mask;
    logic [hjcf_pkg::SPEED_W-1:0]  r_cmd_digit, n_cmd_digit;

    logic                          accept;
    logic                          changed;
    logic                          known;
    logic [hjcf_pkg::ACTION_W-1:0] pair_sel;
    hjcf_pkg::t_desc               desc;

    assign accept   = i_valid && !i_queue_full;
    assign o_ready  = !i_queue_full;
    assign changed  = (r_prev != i_action);
    assign known    = (i_action >= hjcf_pkg::ACTION_FIRST) &&
                      (i_action <= hjcf_pkg::ACTION_LAST);
    assign pair_sel = (i_action - hjcf_pkg::ACTION_FIRST) >> 1;

    always_comb begin
        n_prev      = r_prev;
        n_resend    = r_resend;
        n_cmd_minus = r_cmd_minus;
        n_cmd_mask  = r_cmd_mask;
        n_cmd_digit = r_cmd_digit;
        desc        = '0;

        desc.has_stop   = (r_prev[0] ^ i_action[0]) && (r_prev != hjcf_pkg::ACTION_STOP);
        desc.stop_minus = r_prev[0];

        if (changed) begin
            n_resend    = '0;
            n_cmd_digit = (r_speed > hjcf_pkg::SPEED_MAX) ? hjcf_pkg::SPEED_MAX : r_speed;
            if (known) begin
                n_prev      = i_action;
                n_cmd_minus = i_action[0];
                n_cmd_mask  = hjcf_pkg::pair_mask(pair_sel[3:0]);
            end else begin
                n_prev      = hjcf_pkg::ACTION_STOP;
                n_cmd_minus = 1'b0;
                n_cmd_mask  = '0;
            end
            desc.has_cmd = 1'b1;
        end else if (r_resend < hjcf_pkg::RESEND_LIMIT) begin
            n_resend     = r_resend + 1'b1;
            desc.has_cmd = 1'b1;
        end

        desc.cmd_minus = n_cmd_minus;
        desc.cmd_mask  = n_cmd_mask;
        desc.cmd_digit = n_cmd_digit;
    end

    assign o_push = accept && (desc.has_stop || desc.has_cmd);
    assign o_desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= hjcf_pkg::SPEED_RESET;
            r_prev      <= hjcf_pkg::ACTION_STOP;
            r_resend    <= '0;
            r_cmd_minus <= 1'b0;
            r_cmd_mask  <= '0;
            r_cmd_digit <= '0;
        end else begin
            if (i_cfg_we) begin
                r_speed <= i_cfg_wdata;
            end
            if (accept) begin
                r_prev      <= n_prev;
                r_resend    <= n_resend;
                r_cmd_minus <= n_cmd_minus;
                r_cmd_mask  <= n_cmd_mask;
                r_cmd_digit <= n_cmd_digit;
            end
        end
    end

endmodule

// ----- rtl/hjcf_queue.sv -----
`timescale 1ns / 1ps

module hjcf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hjcf_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output hjcf_pkg::t_desc o_head
);

    hjcf_pkg::t_desc                     r_mem [hjcf_pkg::QUEUE_DEPTH];
    logic [hjcf_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [hjcf_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [hjcf_pkg::QUEUE_CNT_W-1:0]    r_count;

    assign o_full  = (r_count == hjcf_pkg::QUEUE_CNT_W'(hjcf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/hjcf_back.sv -----
`timescale 1ns / 1ps

module hjcf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hjcf_pkg::t_desc i_head,
    output logic            o_pop,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata,
    output logic            o_m_tlast
);

    logic [hjcf_pkg::IDX_W-1:0] r_idx;
    logic                       r_stop_done;
    logic                       r_valid;
    logic [7:0]                 r_data;
    logic                       r_last;

    logic                       advance;
    logic                       in_stop;
    logic                       run_end;
    logic                       item_end;
    logic                       minus;
    hjcf_pkg::t_mask            mask;

    assign advance  = i_valid && (!r_valid || i_m_tready);
    assign in_stop  = i_head.has_stop && !r_stop_done;
    assign run_end  = (r_idx == hjcf_pkg::LAST_IDX);
    assign item_end = run_end && (!in_stop || !i_head.has_cmd);
    assign minus    = in_stop ? i_head.stop_minus : i_head.cmd_minus;
    assign mask     = in_stop ? '0 : i_head.cmd_mask;
    assign o_pop    = advance && item_end;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_data <= hjcf_pkg::cmd_byte(minus, mask, i_head.cmd_digit, r_idx);
            r_last <= item_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_stop_done <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                if (run_end) begin
                    r_idx       <= '0;
                    r_stop_done <= !item_end;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

// ----- rtl/hand_joint_command_framer_core.sv -----
`timescale 1ns / 1ps
// Channel     Direction  Ports                               Contents
// s (input)   in         i_s_tvalid, o_s_tready, i_s_tdata   action_code in bits 4:0
// m (output)  out        o_m_tvalid, i_m_tready, o_m_tdata   out_byte, last_byte on o_m_tlast
// cfg         in         i_cfg_we, i_cfg_wdata               joint_speed
//
// An action yields 0, 13 or 26 bytes, one per cycle from the output register unless o_m stalls.
// The output byte sequencer, not the front, sets how fast actions drain.
// A two-entry command queue lets the front take actions while bytes stream out.
// Reset is synchronous and clears the queue, output valid flag and stored command.
// A stall on o_m holds the current byte and, once the queue fills, o_s_tready.

module hand_joint_command_framer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [4:0] action_code, [7:5] zero
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);

    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_valid;
    hjcf_pkg::t_desc push_desc;
    hjcf_pkg::t_desc head_desc;

    hjcf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_s_tvalid),
        .i_action     (i_s_tdata[hjcf_pkg::ACTION_W-1:0]),
        .i_queue_full (queue_full),
        .o_ready      (o_s_tready),
        .o_push       (push),
        .o_desc       (push_desc)
    );

    hjcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_head  (head_desc)
    );

    hjcf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (queue_valid),
        .i_head     (head_desc),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- rtl/hjcf_checker.sv -----
`timescale 1ns / 1ps

module hjcf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled transfer changed");

    a_last_is_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata == hjcf_pkg::CHAR_CR)
        else $error("final byte is not a carriage return");

    a_byte_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata == hjcf_pkg::CHAR_PLUS) || (o_m_tdata == hjcf_pkg::CHAR_MINUS) ||
            (o_m_tdata == hjcf_pkg::CHAR_CR) ||
            ((o_m_tdata >= hjcf_pkg::CHAR_ZERO) && (o_m_tdata <= hjcf_pkg::CHAR_NINE)))
        else $error("illegal command byte");

endmodule

bind hand_joint_command_framer_core hjcf_checker u_hjcf_checker (.*);
